@@ sv/kaa_pkg.sv @@
// Shared types and constants of the k-means assign and accumulate unit.
`timescale 1ns / 1ps
package kaa_pkg;

  localparam int IN_FW    = 16;
  localparam int LANES_IN = 8;
  localparam int COUNT_W  = 13;
  localparam int DIST_W   = 35;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_LOAD   = 3'd1;
  localparam logic [2:0] FUNC_ASSIGN = 3'd2;
  localparam logic [2:0] FUNC_UPDATE = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  localparam logic REG_NUM_CLUSTERS = 1'b0;
  localparam logic REG_NUM_FEATURES = 1'b1;

  typedef struct packed {
    logic [2:0]        func;
    logic [11:0]       point_index;
    logic [3:0]        cluster_slot;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic signed [15:0] feature_4;
    logic signed [15:0] feature_5;
    logic signed [15:0] feature_6;
    logic signed [15:0] feature_7;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        cluster_index;
    logic [34:0]       best_distance;
    logic              any_changed;
    logic [12:0]       member_count;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
    logic signed [15:0] coord_4;
    logic signed [15:0] coord_5;
    logic signed [15:0] coord_6;
    logic signed [15:0] coord_7;
  } out_item_t;

  typedef struct packed {
    logic sq_en;
    logic div_start;
  } lane_ctl_t;

endpackage

@@ sv/kmeans_assign_accumulate_unit.sv @@
// Top level of the k-means assign and accumulate unit.
`timescale 1ns / 1ps
// Lloyd k-means engine. Commands enter on start while busy is low; every command gives one
// result beat on out_valid for exactly one cycle, and the receiver cannot stall it. After
// reset busy stays high while the assignment memory is swept to unassigned. Clear, load and
// unused codes return their beat in the next cycle and take the next command at once; a read
// registers the slot's memory words and builds its beat from them in S_RDOUT. An assign holds
// busy while the centroid memory feeds the feature lanes one centroid per cycle, followed by
// the lane, merge and compare stages and one read-modify-write of the sums. An update reads
// each cluster in turn, skips an empty one and runs the bit-serial dividers, one per lane,
// for a filled one.
module kmeans_assign_accumulate_unit #(
  parameter int MAX_CLUSTERS  = 16,
  parameter int MAX_FEATURES  = 8,
  parameter int MAX_POINTS    = 4096,
  parameter int FEATURE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kaa_pkg::in_item_t   in_data,
  output logic                out_valid,
  output kaa_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import kaa_pkg::*;

  localparam int FW   = FEATURE_WIDTH;
  localparam int CIW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW   = FW + COUNT_W;
  localparam int SQW  = 2 * FW + 1;
  localparam int DSW  = SQW + $clog2(MAX_FEATURES);
  localparam int DXW  = (DSW > DIST_W) ? DSW : DIST_W;
  localparam int ROWC = MAX_FEATURES * FW;
  localparam int ROWS = MAX_FEATURES * SW + COUNT_W;
  localparam longint RECIP = (64'd1 << 24) / MAX_POINTS
                             + (((64'd1 << 24) % MAX_POINTS) != 0 ? 1 : 0);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SRCH    = 4'd2;
  localparam logic [3:0] S_DRAIN   = 4'd3;
  localparam logic [3:0] S_FETCH   = 4'd4;
  localparam logic [3:0] S_WB      = 4'd5;
  localparam logic [3:0] S_UPD_RD  = 4'd6;
  localparam logic [3:0] S_UPD_CHK = 4'd7;
  localparam logic [3:0] S_UPD_DIV = 4'd8;
  localparam logic [3:0] S_RDOUT   = 4'd9;

  localparam logic [KW-1:0] UNASSIGNED = KW'(MAX_CLUSTERS);

  // configuration
  logic [4:0]    nc_r;
  logic [3:0]    nf_r;
  logic [KW-1:0] k_eff;
  logic [3:0]    nf_eff;
  logic          cfg_wr;

  // control
  logic [3:0]     state_r, state_nxt;
  logic [CIW-1:0] j_r, j_nxt;
  logic           v0_r, v1_r;
  logic [CIW-1:0] j0_r, j1_r;
  logic           flag_r, flag_nxt;
  logic [PW-1:0]  clr_cnt_r;
  logic           slot_ok_r;
  logic           out_valid_r, out_fire;
  out_item_t      out_r, out_nxt;
  logic           acc, slot_ok, last_j;

  // item registers
  in_item_t       cmd_r;
  logic signed [FW-1:0] feat_r  [MAX_FEATURES];
  logic signed [FW-1:0] feat_fw [MAX_FEATURES];
  logic signed [IN_FW-1:0] feat_in [LANES_IN];
  logic [11:0]    q_r;
  logic [PW-1:0]  pidx_r;
  logic [36:0]    q_prod;
  logic [28:0]    m_prod;

  // memories
  logic [ROWC-1:0] cen_mem [MAX_CLUSTERS];
  logic [ROWS-1:0] sum_mem [MAX_CLUSTERS];
  logic [KW-1:0]   asg_mem [MAX_POINTS];
  logic [MAX_CLUSTERS-1:0] cen_vld_r, sum_vld_r;
  logic [ROWC-1:0] cen_q_r;
  logic [ROWS-1:0] sum_q_r;
  logic            cen_vq_r, sum_vq_r;
  logic [KW-1:0]   asg_q_r;
  logic            cen_re, cen_we, sum_re, sum_we, sum_clr, asg_re, asg_we;
  logic [CIW-1:0]  cen_ra, cen_wa, sum_ra;
  logic [ROWC-1:0] cen_wd;
  logic [ROWS-1:0] sum_wd;
  logic [PW-1:0]   asg_wa;
  logic [KW-1:0]   asg_wd;

  // lanes and merge
  lane_ctl_t               lane_ctl;
  logic [MAX_FEATURES-1:0] lane_act;
  logic signed [FW-1:0]    cen_lane [MAX_FEATURES];
  logic signed [SW-1:0]    sum_old  [MAX_FEATURES];
  logic signed [FW-1:0]    quo      [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] div_done_v;
  logic [MAX_FEATURES-1:0][SQW-1:0] sq_all;
  logic                    mrg_pending;
  logic [CIW-1:0]          best_idx;
  logic [DSW-1:0]          best_dist;

  // writeback values
  logic [COUNT_W-1:0] cnt_old, cnt_new;
  logic               inc;
  logic [DIST_W-1:0]  dist_sat;
  logic [ROWC-1:0]    cen_upd;
  logic [ROWC-1:0]    cen_load;
  logic signed [15:0] coord16 [LANES_IN];

  assign busy      = (state_r != S_IDLE);
  assign acc       = start && !busy;
  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_NUM_FEATURES) ? {28'd0, nf_r} : {27'd0, nc_r};
  assign slot_ok   = ({4'd0, in_data.cluster_slot} < 8'(MAX_CLUSTERS));
  assign last_j    = (KW'(j_r) == k_eff - KW'(1));

  assign feat_in[0] = in_data.feature_0;
  assign feat_in[1] = in_data.feature_1;
  assign feat_in[2] = in_data.feature_2;
  assign feat_in[3] = in_data.feature_3;
  assign feat_in[4] = in_data.feature_4;
  assign feat_in[5] = in_data.feature_5;
  assign feat_in[6] = in_data.feature_6;
  assign feat_in[7] = in_data.feature_7;

  always_comb begin
    logic signed [23:0] ext_v;
    for (int d = 0; d < MAX_FEATURES; d++) begin
      // narrower widths wrap, wider ones sign-extend
      ext_v      = 24'(feat_in[d]);
      feat_fw[d] = ext_v[FW-1:0];
      cen_load[d*FW +: FW] = ext_v[FW-1:0];
    end
  end

  always_comb begin
    if (nc_r == 5'd0) begin
      k_eff = KW'(1);
    end else if ({3'd0, nc_r} > 8'(MAX_CLUSTERS)) begin
      k_eff = KW'(MAX_CLUSTERS);
    end else begin
      k_eff = KW'(nc_r);
    end
    if (nf_r == 4'd0) begin
      nf_eff = 4'd1;
    end else if (nf_r > 4'(MAX_FEATURES)) begin
      nf_eff = 4'(MAX_FEATURES);
    end else begin
      nf_eff = nf_r;
    end
    for (int d = 0; d < MAX_FEATURES; d++) begin
      lane_act[d] = (4'(d) < nf_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= 5'd1;
      nf_r <= 4'd8;
    end else if (cfg_wr) begin
      priority if (paddr[2] == REG_NUM_CLUSTERS) begin
        nc_r <= pwdata[4:0];
      end else begin
        nf_r <= pwdata[3:0];
      end
    end
  end

  // point index modulo MAX_POINTS by exact reciprocal over two stages
  assign q_prod = 37'(cmd_r.point_index) * 37'(RECIP);
  assign m_prod = 29'(q_r) * 29'(MAX_POINTS);

  always_ff @(posedge clk) begin
    q_r    <= q_prod[35:24];
    pidx_r <= PW'(cmd_r.point_index - m_prod[11:0]);
    if (acc) begin
      cmd_r <= in_data;
      for (int d = 0; d < MAX_FEATURES; d++) begin
        feat_r[d] <= feat_fw[d];
      end
    end
  end

  // read data views
  always_comb begin
    cnt_old = sum_vq_r ? sum_q_r[MAX_FEATURES*SW +: COUNT_W] : '0;
    inc     = (cnt_old < COUNT_MAX);
    cnt_new = inc ? cnt_old + COUNT_W'(1) : cnt_old;
    for (int d = 0; d < MAX_FEATURES; d++) begin
      cen_lane[d] = cen_vq_r ? cen_q_r[d*FW +: FW] : '0;
      sum_old[d]  = sum_vq_r ? sum_q_r[d*SW +: SW] : '0;
      sum_wd[d*SW +: SW] = (lane_act[d] && inc) ? sum_old[d] + SW'(feat_r[d]) : sum_old[d];
      cen_upd[d*FW +: FW] = lane_act[d] ? quo[d] : cen_lane[d];
    end
    sum_wd[MAX_FEATURES*SW +: COUNT_W] = cnt_new;
    for (int d = 0; d < LANES_IN; d++) begin
      coord16[d] = '0;
    end
    for (int d = 0; d < MAX_FEATURES; d++) begin
      coord16[d] = 16'(cen_lane[d]);
    end
    if (DXW'(best_dist) > DXW'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = DIST_W'(best_dist);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    j_nxt             = j_r;
    flag_nxt          = flag_r;
    out_fire          = 1'b0;
    out_nxt           = '0;
    cen_re            = 1'b0;
    cen_ra            = j_r;
    cen_we            = 1'b0;
    cen_wa            = j_r;
    cen_wd            = cen_upd;
    sum_re            = 1'b0;
    sum_ra            = j_r;
    sum_we            = 1'b0;
    sum_clr           = 1'b0;
    asg_re            = 1'b0;
    asg_we            = 1'b0;
    asg_wa            = pidx_r;
    asg_wd            = KW'(best_idx);
    lane_ctl.sq_en     = v0_r;
    lane_ctl.div_start = 1'b0;
    unique case (state_r)
      S_CLR: begin
        asg_we = 1'b1;
        asg_wa = clr_cnt_r;
        asg_wd = UNASSIGNED;
        if (clr_cnt_r == PW'(MAX_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          unique case (in_data.func)
            FUNC_CLEAR: begin
              sum_clr  = 1'b1;
              flag_nxt = 1'b0;
              out_fire = 1'b1;
            end
            FUNC_LOAD: begin
              cen_we   = slot_ok;
              cen_wa   = CIW'(in_data.cluster_slot);
              cen_wd   = cen_load;
              out_fire = 1'b1;
            end
            FUNC_ASSIGN: begin
              j_nxt     = '0;
              state_nxt = S_SRCH;
            end
            FUNC_UPDATE: begin
              j_nxt     = '0;
              state_nxt = S_UPD_RD;
            end
            FUNC_READ: begin
              cen_re    = slot_ok;
              sum_re    = slot_ok;
              cen_ra    = CIW'(in_data.cluster_slot);
              sum_ra    = CIW'(in_data.cluster_slot);
              state_nxt = S_RDOUT;
            end
            default: begin
              out_fire = 1'b1;
            end
          endcase
        end
      end
      S_SRCH: begin
        cen_re = 1'b1;
        if (last_j) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + CIW'(1);
        end
      end
      S_DRAIN: begin
        if (!(v0_r || v1_r || mrg_pending)) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cen_re    = 1'b1;
        cen_ra    = best_idx;
        sum_re    = 1'b1;
        sum_ra    = best_idx;
        asg_re    = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        sum_we   = 1'b1;
        asg_we   = 1'b1;
        flag_nxt = flag_r || (asg_q_r != KW'(best_idx));
        out_fire = 1'b1;
        out_nxt.cluster_index = 4'(best_idx);
        out_nxt.best_distance = dist_sat;
        out_nxt.member_count  = cnt_new;
        state_nxt = S_IDLE;
      end
      S_UPD_RD: begin
        cen_re    = 1'b1;
        sum_re    = 1'b1;
        state_nxt = S_UPD_CHK;
      end
      S_UPD_CHK: begin
        if (cnt_old == '0) begin
          if (last_j) begin
            out_fire  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + CIW'(1);
            state_nxt = S_UPD_RD;
          end
        end else begin
          lane_ctl.div_start = 1'b1;
          state_nxt          = S_UPD_DIV;
        end
      end
      S_UPD_DIV: begin
        if (&div_done_v) begin
          cen_we = 1'b1;
          if (last_j) begin
            out_fire  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + CIW'(1);
            state_nxt = S_UPD_RD;
          end
        end
      end
      S_RDOUT: begin
        out_fire = 1'b1;
        out_nxt.cluster_index = cmd_r.cluster_slot;
        out_nxt.member_count  = slot_ok_r ? cnt_old : '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if ((state_r == S_WB) || (state_r == S_RDOUT && slot_ok_r)) begin
      out_nxt.coord_0 = coord16[0];
      out_nxt.coord_1 = coord16[1];
      out_nxt.coord_2 = coord16[2];
      out_nxt.coord_3 = coord16[3];
      out_nxt.coord_4 = coord16[4];
      out_nxt.coord_5 = coord16[5];
      out_nxt.coord_6 = coord16[6];
      out_nxt.coord_7 = coord16[7];
    end
    out_nxt.any_changed = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      j_r         <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cen_vld_r   <= '0;
      sum_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_r + PW'(1);
      j_r         <= j_nxt;
      v0_r        <= (state_r == S_SRCH);
      v1_r        <= v0_r;
      flag_r      <= flag_nxt;
      out_valid_r <= out_fire;
      if (cen_we) begin
        cen_vld_r[cen_wa] <= 1'b1;
      end
      if (sum_clr) begin
        sum_vld_r <= '0;
      end else if (sum_we) begin
        sum_vld_r[best_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    j0_r  <= j_r;
    j1_r  <= j0_r;
    out_r <= out_nxt;
    if (acc) begin
      slot_ok_r <= slot_ok;
    end
  end

  // centroid memory
  always_ff @(posedge clk) begin
    if (cen_we) begin
      cen_mem[cen_wa] <= cen_wd;
    end
    if (cen_re) begin
      cen_q_r  <= cen_mem[cen_ra];
      cen_vq_r <= cen_vld_r[cen_ra];
    end
  end

  // sum and count memory
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[best_idx] <= sum_wd;
    end
    if (sum_re) begin
      sum_q_r  <= sum_mem[sum_ra];
      sum_vq_r <= sum_vld_r[sum_ra];
    end
  end

  // assignment memory
  always_ff @(posedge clk) begin
    if (asg_we) begin
      asg_mem[asg_wa] <= asg_wd;
    end
    if (asg_re) begin
      asg_q_r <= asg_mem[pidx_r];
    end
  end

  for (genvar d = 0; d < MAX_FEATURES; d++) begin : g_lane
    kaa_lane #(
      .FW(FW),
      .SW(SW)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .feat     (feat_r[d]),
      .cen      (cen_lane[d]),
      .act      (lane_act[d]),
      .dividend (sum_old[d]),
      .divisor  (cnt_old),
      .sq       (sq_all[d]),
      .quo      (quo[d]),
      .done     (div_done_v[d])
    );
  end

  kaa_merge #(
    .N  (MAX_FEATURES),
    .SQW(SQW),
    .IW (CIW)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v1_r),
    .in_idx   (j1_r),
    .sq       (sq_all),
    .pending  (mrg_pending),
    .best_idx (best_idx),
    .best_dist(best_dist)
  );

endmodule

@@ sv/kaa_div.sv @@
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
`timescale 1ns / 1ps
module kaa_div #(
  parameter int DW = 29,
  parameter int VW = 13,
  parameter int QW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic signed [QW-1:0] quo,
  output logic                 done
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW-1:0] mag;
  logic [VW:0]   trial;
  logic [VW:0]   diff_v;
  logic [DW-1:0] quo_full;

  assign mag      = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
  assign trial    = {rem_r, q_r[DW-1]};
  assign diff_v   = trial - {1'b0, dvs_r};
  assign quo_full = neg_r ? DW'(-q_r) : q_r;
  assign quo      = quo_full[QW-1:0];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[DW-1];
    end else if (run_r) begin
      // restore when the trial remainder falls below the divisor
      if (!diff_v[VW]) begin
        rem_r <= diff_v[VW-1:0];
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[VW-1:0];
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/kaa_lane.sv @@
// One feature lane: squared difference for the search and divider for the update.
`timescale 1ns / 1ps
module kaa_lane #(
  parameter int FW = 16,
  parameter int SW = 29
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kaa_pkg::lane_ctl_t            ctl,
  input  logic signed [FW-1:0]          feat,
  input  logic signed [FW-1:0]          cen,
  input  logic                          act,
  input  logic signed [SW-1:0]          dividend,
  input  logic [kaa_pkg::COUNT_W-1:0]   divisor,
  output logic [2*FW:0]                 sq,
  output logic signed [FW-1:0]          quo,
  output logic                          done
);
  import kaa_pkg::*;

  logic signed [FW:0]     diff;
  logic signed [2*FW+1:0] prod;
  logic [2*FW:0]          sq_r;

  assign diff = (FW+1)'(feat) - (FW+1)'(cen);
  assign prod = diff * diff;
  assign sq   = sq_r;

  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      sq_r <= act ? prod[2*FW:0] : '0;
    end
  end

  kaa_div #(
    .DW(SW),
    .VW(COUNT_W),
    .QW(FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quo      (quo),
    .done     (done)
  );

endmodule

@@ sv/kaa_merge.sv @@
// Merging stage: sums the lane squares and keeps the nearest centroid.
`timescale 1ns / 1ps
module kaa_merge #(
  parameter int N   = 8,
  parameter int SQW = 33,
  parameter int IW  = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [IW-1:0]                   in_idx,
  input  logic [N-1:0][SQW-1:0]           sq,
  output logic                            pending,
  output logic [IW-1:0]                   best_idx,
  output logic [SQW+$clog2(N)-1:0]        best_dist
);
  localparam int DSW = SQW + $clog2(N);

  logic [DSW-1:0] sum;
  logic [DSW-1:0] dist_r;
  logic [IW-1:0]  j2_r;
  logic           v2_r;
  logic [IW-1:0]  best_idx_r;
  logic [DSW-1:0] best_dist_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < N; i++) begin
      sum = sum + DSW'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= sum;
    j2_r   <= in_idx;
    // first centroid seeds the search; strict less keeps the lowest index on ties
    if (v2_r && (j2_r == '0 || dist_r < best_dist_r)) begin
      best_idx_r  <= j2_r;
      best_dist_r <= dist_r;
    end
  end

  assign pending   = v2_r;
  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;

endmodule

@@ sv/kaa_checker.sv @@
// Port-level checks of the k-means unit and their bind to the top level.
`timescale 1ns / 1ps
module kaa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input kaa_pkg::out_item_t out_data
);
  import kaa_pkg::*;

  // an accepted command either occupies the block or returns its beat next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither busy nor answered");

  // a result beat leaves the block ready for the next command
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // no beat without a command in flight
  a_out_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result beat with no command");

  // a distance comes only from an assign, which always holds busy
  a_dist_from_assign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.best_distance != '0) |-> $past(busy))
    else $error("distance reported outside an assign");

endmodule

bind kmeans_assign_accumulate_unit kaa_checker u_kaa_checker (.*);
